// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/lev_pkg.sv
// ----------------------------------------------------------------------------
// lev_pkg
// Types and constants shared by the leader election voting logic.
// ----------------------------------------------------------------------------
package lev_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int ID_W          = 16;
    localparam int TERM_W        = 31;
    localparam int PEER_W        = 4;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 4;
    localparam int ROLE_W        = 2;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 48;

    localparam logic [TERM_W-1:0] TERM_MAX = '1;

    localparam logic [CFG_ADDR_W-1:0] CFG_SELF_ID    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEER_COUNT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_VOTE_REQ = 2'd0,
        KIND_BEGIN    = 2'd1,
        KIND_VOTE_RCV = 2'd2,
        KIND_FAILURE  = 2'd3
    } t_kind;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_PRIMARY   = 2'd0,
        ROLE_REPLICA   = 2'd1,
        ROLE_CANDIDATE = 2'd2
    } t_role;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED       = 4'd0,
        ST_OLD_TERM      = 4'd1,
        ST_ALREADY_VOTED = 4'd2,
        ST_BEGUN         = 4'd3,
        ST_NOT_CANDIDATE = 4'd4,
        ST_COUNTED       = 4'd5,
        ST_PROMOTED      = 4'd6,
        ST_START         = 4'd7,
        ST_BUSY          = 4'd8
    } t_status;

    typedef struct packed {
        logic            clear;
        logic            add;
        logic [ID_W-1:0] id;
    } t_store_cmd;

endpackage

// File: rtl/lev_voter_store.sv
// ----------------------------------------------------------------------------
// lev_voter_store
// Store of distinct voter ids with a parallel duplicate match.
// ----------------------------------------------------------------------------
module lev_voter_store
    import lev_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_cmd       i_cmd,
    output logic [CNT_W-1:0] o_count,
    output logic [CNT_W-1:0] o_count_add
);

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [ID_W-1:0]      r_ids [MAX_NODES];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [MAX_NODES-1:0] w_match;
    logic                 w_dup;
    logic                 w_full;

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            w_match[i] = (CNT_W'(i) < r_count) && (r_ids[i] == i_cmd.id);
        end
        w_dup       = |w_match;
        w_full      = (r_count == CNT_W'(MAX_NODES));
        o_count_add = (w_dup || w_full) ? r_count : r_count + 1'b1;
        n_count     = r_count;
        if (i_cmd.clear) begin
            n_count = CNT_W'(1);
        end else if (i_cmd.add) begin
            n_count = o_count_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_ids[0] <= i_cmd.id;
        end else if (i_cmd.add && !w_dup && !w_full) begin
            r_ids[r_count[IDX_W-1:0]] <= i_cmd.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// File: rtl/lev_core.sv
// ----------------------------------------------------------------------------
// lev_core
// Node state, configuration and the per-word election decision.
// ----------------------------------------------------------------------------
module lev_core
    import lev_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_fire,
    input  t_kind                 i_kind,
    input  logic [TERM_W-1:0]     i_term,
    input  logic [ID_W-1:0]       i_node_id,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [CNT_W-1:0]      i_count_add,
    output t_store_cmd            o_cmd,
    output logic                  o_granted,
    output t_status               o_status,
    output t_role                 o_role,
    output logic [TERM_W-1:0]     o_term,
    output logic [CNT_W-1:0]      o_votes
);

    localparam int MAJ_W = (CNT_W > 5) ? CNT_W : 5;

    t_role             r_role,       n_role;
    logic [TERM_W-1:0] r_term,       n_term;
    logic              r_vote_valid, n_vote_valid;
    logic [ID_W-1:0]   r_vote_id,    n_vote_id;
    logic              r_busy,       n_busy;
    logic [ID_W-1:0]   r_self_id;
    logic [PEER_W-1:0] r_peer_count;
    logic [PEER_W:0]   w_peer_inc;
    logic [MAJ_W-1:0]  w_majority;
    logic              w_vote_free;

    always_comb begin
        n_role       = r_role;
        n_term       = r_term;
        n_vote_valid = r_vote_valid;
        n_vote_id    = r_vote_id;
        n_busy       = r_busy;
        o_granted    = 1'b0;
        o_status     = ST_GRANTED;
        o_votes      = i_count;
        o_cmd        = '0;
        w_peer_inc   = {1'b0, r_peer_count} + 1'b1;
        w_majority   = MAJ_W'(w_peer_inc[PEER_W:1]) + MAJ_W'(1);
        w_vote_free  = 1'b0;

        unique case (i_kind)
            KIND_VOTE_REQ: begin
                if (i_term < r_term) begin
                    o_status = ST_OLD_TERM;
                end else begin
                    if (i_term > r_term) begin
                        n_term       = i_term;
                        n_vote_valid = 1'b0;
                        n_role       = ROLE_REPLICA;
                    end
                    w_vote_free = !n_vote_valid || (r_vote_id == i_node_id);
                    if (w_vote_free) begin
                        n_vote_valid = 1'b1;
                        n_vote_id    = i_node_id;
                        o_granted    = 1'b1;
                        o_status     = ST_GRANTED;
                    end else begin
                        o_status = ST_ALREADY_VOTED;
                    end
                end
            end
            KIND_BEGIN: begin
                n_role       = ROLE_CANDIDATE;
                n_term       = (r_term != TERM_MAX) ? r_term + 1'b1 : r_term;
                n_vote_valid = 1'b1;
                n_vote_id    = r_self_id;
                o_cmd.clear  = i_fire;
                o_cmd.id     = r_self_id;
                o_votes      = CNT_W'(1);
                o_status     = ST_BEGUN;
            end
            KIND_VOTE_RCV: begin
                if (r_role != ROLE_CANDIDATE) begin
                    o_status = ST_NOT_CANDIDATE;
                end else begin
                    o_cmd.add = i_fire;
                    o_cmd.id  = i_node_id;
                    o_votes   = i_count_add;
                    if (MAJ_W'(i_count_add) >= w_majority) begin
                        n_role   = ROLE_PRIMARY;
                        n_busy   = 1'b0;
                        o_status = ST_PROMOTED;
                    end else begin
                        o_status = ST_COUNTED;
                    end
                end
            end
            KIND_FAILURE: begin
                if (r_busy) begin
                    o_status = ST_BUSY;
                end else begin
                    n_busy   = 1'b1;
                    o_status = ST_START;
                end
            end
            default: begin
                o_status = ST_GRANTED;
            end
        endcase

        o_role = n_role;
        o_term = n_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role       <= ROLE_PRIMARY;
            r_term       <= '0;
            r_vote_valid <= 1'b0;
            r_vote_id    <= '0;
            r_busy       <= 1'b0;
        end else if (i_fire) begin
            r_role       <= n_role;
            r_term       <= n_term;
            r_vote_valid <= n_vote_valid;
            r_vote_id    <= n_vote_id;
            r_busy       <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id    <= '0;
            r_peer_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SELF_ID:    r_self_id    <= i_cfg_wdata;
                CFG_PEER_COUNT: r_peer_count <= i_cfg_wdata[PEER_W-1:0];
                default:        r_self_id    <= r_self_id;
            endcase
        end
    end

endmodule

// File: rtl/leader_election_vote_logic.sv
// ----------------------------------------------------------------------------
// leader_election_vote_logic
// Term-based leader election voting for one cluster node.
// ----------------------------------------------------------------------------
// One word is accepted every clock cycle while the master side takes results.
// The word is captured in an input register, then decided in a single pass
// against the node state and the voter store, whose ids are all compared in
// parallel. The result is then held in an output register, from which it is
// presented on the master side. While a finished result waits to be taken,
// the input register can hold one further word. Once both registers are
// full, the slave side stalls until the result is taken. The sustained rate
// is therefore one word per cycle whenever the downstream side is ready.
// ----------------------------------------------------------------------------
module leader_election_vote_logic
    import lev_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // term [30:0], node_id [46:31], zero pad above.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // kind [1:0].
    input  logic [KIND_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // granted, status, role_now, term_now, votes_now from bit 0 up, zero pad.
    output logic [((1 + STATUS_W + ROLE_W + TERM_W + $clog2(MAX_NODES + 1) + 7) / 8) * 8 - 1:0]
                                  o_m_tdata
);

    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int OUT_W      = 1 + STATUS_W + ROLE_W + TERM_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    logic                  r_in_valid;
    t_kind                 r_kind;
    logic [TERM_W-1:0]     r_term;
    logic [ID_W-1:0]       r_node_id;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_fire;
    t_store_cmd            w_cmd;
    logic [CNT_W-1:0]      w_count;
    logic [CNT_W-1:0]      w_count_add;
    logic                  w_granted;
    t_status               w_status;
    t_role                 w_role;
    logic [TERM_W-1:0]     w_term;
    logic [CNT_W-1:0]      w_votes;

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_kind    <= t_kind'(i_s_tuser);
            r_term    <= i_s_tdata[TERM_W-1:0];
            r_node_id <= i_s_tdata[TERM_W +: ID_W];
        end
    end

    lev_voter_store #(
        .MAX_NODES (MAX_NODES),
        .CNT_W     (CNT_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_count     (w_count),
        .o_count_add (w_count_add)
    );

    lev_core #(
        .MAX_NODES (MAX_NODES),
        .CNT_W     (CNT_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_kind      (r_kind),
        .i_term      (r_term),
        .i_node_id   (r_node_id),
        .i_count     (w_count),
        .i_count_add (w_count_add),
        .o_cmd       (w_cmd),
        .o_granted   (w_granted),
        .o_status    (w_status),
        .o_role      (w_role),
        .o_term      (w_term),
        .o_votes     (w_votes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= OUT_DATA_W'({w_votes, w_term, w_role, w_status, w_granted});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: rtl/lev_checker.sv
// ----------------------------------------------------------------------------
// lev_checker
// Port-level assertions for the leader election voting logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lev_checker
    import lev_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [((1 + STATUS_W + ROLE_W + TERM_W + $clog2(MAX_NODES + 1) + 7) / 8) * 8 - 1:0]
                i_m_tdata
);

    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int ST_LO   = 1;
    localparam int ROLE_LO = ST_LO + STATUS_W;
    localparam int VOTE_LO = ROLE_LO + ROLE_W + TERM_W;

    logic             w_granted;
    logic [STATUS_W-1:0] w_status;
    logic [ROLE_W-1:0]   w_role;
    logic [CNT_W-1:0]    w_votes;

    assign w_granted = i_m_tdata[0];
    assign w_status  = i_m_tdata[ST_LO +: STATUS_W];
    assign w_role    = i_m_tdata[ROLE_LO +: ROLE_W];
    assign w_votes   = i_m_tdata[VOTE_LO +: CNT_W];

    `ASSERT_IMPLY(a_granted_status, i_clk, i_rst_n, i_m_tvalid && w_granted,
        w_status == ST_GRANTED)

    `ASSERT_IMPLY(a_promoted_primary, i_clk, i_rst_n,
        i_m_tvalid && (w_status == ST_PROMOTED),
        (w_role == ROLE_PRIMARY) && (w_votes != '0))

    `ASSERT_IMPLY(a_begun_state, i_clk, i_rst_n, i_m_tvalid && (w_status == ST_BEGUN),
        (w_role == ROLE_CANDIDATE) && (w_votes == CNT_W'(1)))

    `ASSERT_IMPLY(a_votes_bound, i_clk, i_rst_n, i_m_tvalid, w_votes <= CNT_W'(MAX_NODES))

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata))

endmodule

bind leader_election_vote_logic lev_checker #(
    .MAX_NODES (MAX_NODES)
) u_lev_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
